@@ rtl/sbrp_pkg.sv @@
// shared command, status and state codes for the slotted byte ring pipe
`default_nettype none

package sbrp_pkg;

    typedef enum logic [2:0] {
        CMD_PRODUCE_ACQUIRE = 3'd0,
        CMD_PRODUCE_BYTE    = 3'd1,
        CMD_PRODUCE_COMMIT  = 3'd2,
        CMD_CONSUME_ACQUIRE = 3'd3,
        CMD_CONSUME_BYTE    = 3'd4,
        CMD_CONSUME_COMMIT  = 3'd5,
        CMD_SPARE_A         = 3'd6,
        CMD_SPARE_B         = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_FETCH = 3'b100
    } state_t;

    localparam int unsigned WAIT_MAX = 255;

endpackage

`default_nettype wire

@@ rtl/slotted_byte_ring_pipe_top.sv @@
// top level of the slotted byte ring pipe: slot table, byte ring and command sequencer
`default_nettype none

// Byte ring of BUFFER_DEPTH entries shared by producers and consumers through a
// round-robin table of SLOT_COUNT message slots. One request carries one command
// (produce acquire, produce byte, produce commit, consume acquire, consume byte,
// consume commit) and returns exactly one result; busy, full and not-ready
// results must be retried by the caller. Rate: the block works on one request at
// a time. The slot position memory is read at the accepting edge and the result
// is registered from the slot lookup state when the result register is free.
// Consume byte passes through slot lookup and then the ring fetch state before
// its result is registered, because the ring address comes out of the slot
// position memory and the ring read follows it. A result held by out_stall
// holds back the final step of the next request; a new request is accepted as
// soon as the sequencer is idle, even while the previous result still waits.
// BUFFER_DEPTH must be a power of two, ring addresses are the low bits of a
// position. The ring needs no clearing pass after reset (unwritten bytes read
// as anything); slot positions carry a valid bit per entry, so reset takes
// effect at once.
module slotted_byte_ring_pipe_top
    import sbrp_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 4096,
    parameter int unsigned SLOT_COUNT   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [12:0] amount,
    input  wire logic [3:0]  slot_in,
    input  wire logic [31:0] write_position,
    input  wire logic [7:0]  data_in,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [3:0]       slot_out,
    output logic [31:0]      position_out,
    output logic [7:0]       data_out,
    output logic             wake_writers
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned SW = $clog2(SLOT_COUNT);

    // slot numbers on the port are 4 bits, fold them into the table
    function automatic logic [SW-1:0] slot_wrap(input logic [3:0] v);
        logic [6:0] t;
        t = 7'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 7'(SLOT_COUNT))
            begin
                t = t - 7'(SLOT_COUNT);
            end
        end
        return SW'(t);
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(SLOT_COUNT - 1)) ? '0 : s + SW'(1);
    endfunction

    // sequencer and architectural state
    state_t                  state_reg, state_next;
    logic [31:0]             write_total_reg, write_total_next;
    logic [31:0]             read_total_reg, read_total_next;
    logic [SW-1:0]           prod_slot_reg, prod_slot_next;
    logic [SW-1:0]           cons_slot_reg, cons_slot_next;
    logic [SLOT_COUNT-1:0]   taken_reg, taken_next;
    logic [SLOT_COUNT-1:0]   ready_reg, ready_next;
    logic [SLOT_COUNT-1:0]   pos_vld_reg, pos_vld_next;
    logic [7:0]              waiting_reg, waiting_next;

    // captured request
    cmd_t                    cmd_reg;
    logic [12:0]             amount_reg;
    logic [SW-1:0]           slot_reg;
    logic [31:0]             wpos_reg;
    logic [7:0]              din_reg;

    // result register
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic [3:0]              slot_out_reg, slot_out_next;
    logic [31:0]             pos_out_reg, pos_out_next;
    logic [7:0]              data_out_reg, data_out_next;
    logic                    wake_reg, wake_next;

    // slot position memory
    logic [31:0]             pos_mem [SLOT_COUNT];
    logic [31:0]             pos_rdata_reg;
    logic                    pos_rvld_reg;
    logic [SW-1:0]           pos_raddr;
    logic                    pos_we;
    logic [SW-1:0]           pos_waddr;
    logic [31:0]             pos_wdata;
    logic [31:0]             pos_value;

    // byte ring memory
    logic [7:0]              ring_mem [BUFFER_DEPTH];
    logic [7:0]              ring_rdata_reg;
    logic                    ring_re;
    logic [AW-1:0]           ring_raddr;
    logic                    ring_we;

    logic                    accept;
    logic                    fire;
    logic [SW-1:0]           in_slot;
    logic [31:0]             fill;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    // the result register is free, or is being emptied this cycle
    assign fire      = !out_valid_reg || !out_stall;
    assign in_slot   = slot_wrap(slot_in);
    assign pos_raddr = (cmd_t'(command) == CMD_CONSUME_ACQUIRE) ? cons_slot_reg : in_slot;
    // a slot position never written since reset reads as zero
    assign pos_value = pos_rvld_reg ? pos_rdata_reg : 32'd0;
    assign fill      = wpos_reg - read_total_reg;
    assign ring_raddr = pos_value[AW-1:0];

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_out     = slot_out_reg;
    assign position_out = pos_out_reg;
    assign data_out     = data_out_reg;
    assign wake_writers = wake_reg;

    always_comb
    begin
        state_next       = state_reg;
        write_total_next = write_total_reg;
        read_total_next  = read_total_reg;
        prod_slot_next   = prod_slot_reg;
        cons_slot_next   = cons_slot_reg;
        taken_next       = taken_reg;
        ready_next       = ready_reg;
        pos_vld_next     = pos_vld_reg;
        waiting_next     = waiting_reg;
        status_next      = status_reg;
        slot_out_next    = slot_out_reg;
        pos_out_next     = pos_out_reg;
        data_out_next    = data_out_reg;
        wake_next        = wake_reg;
        out_valid_next   = out_valid_reg && out_stall;
        pos_we           = 1'b0;
        pos_waddr        = slot_reg;
        pos_wdata        = pos_value;
        ring_we          = 1'b0;
        ring_re          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (cmd_reg == CMD_CONSUME_BYTE)
                begin
                    // fetch the byte and step the slot position
                    ring_re      = 1'b1;
                    pos_we       = 1'b1;
                    pos_waddr    = slot_reg;
                    pos_wdata    = pos_value + 32'd1;
                    pos_vld_next[slot_reg] = 1'b1;
                    state_next   = S_FETCH;
                end
                else if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    slot_out_next  = 4'd0;
                    pos_out_next   = 32'd0;
                    data_out_next  = 8'd0;
                    wake_next      = 1'b0;
                    case (cmd_reg)
                        CMD_PRODUCE_ACQUIRE:
                        begin
                            slot_out_next = 4'(prod_slot_reg);
                            if (taken_reg[prod_slot_reg])
                            begin
                                status_next = ST_BUSY;
                            end
                            else
                            begin
                                taken_next[prod_slot_reg]   = 1'b1;
                                pos_we                      = 1'b1;
                                pos_waddr                   = prod_slot_reg;
                                pos_wdata                   = write_total_reg;
                                pos_vld_next[prod_slot_reg] = 1'b1;
                                pos_out_next                = write_total_reg;
                                write_total_next = write_total_reg + 32'(amount_reg);
                                prod_slot_next   = slot_inc(prod_slot_reg);
                            end
                        end
                        CMD_PRODUCE_BYTE:
                        begin
                            if (fill >= 32'(BUFFER_DEPTH))
                            begin
                                status_next  = ST_FULL;
                                pos_out_next = wpos_reg;
                                if (waiting_reg != 8'(WAIT_MAX))
                                begin
                                    waiting_next = waiting_reg + 8'd1;
                                end
                            end
                            else
                            begin
                                ring_we      = 1'b1;
                                pos_out_next = wpos_reg + 32'd1;
                            end
                        end
                        CMD_PRODUCE_COMMIT:
                        begin
                            slot_out_next        = 4'(slot_reg);
                            ready_next[slot_reg] = 1'b1;
                        end
                        CMD_CONSUME_ACQUIRE:
                        begin
                            slot_out_next = 4'(cons_slot_reg);
                            if (!ready_reg[cons_slot_reg])
                            begin
                                status_next = ST_NOT_READY;
                            end
                            else
                            begin
                                pos_out_next   = pos_value;
                                cons_slot_next = slot_inc(cons_slot_reg);
                            end
                        end
                        CMD_CONSUME_COMMIT:
                        begin
                            slot_out_next        = 4'(slot_reg);
                            taken_next[slot_reg] = 1'b0;
                            ready_next[slot_reg] = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (fire)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    status_next     = ST_OK;
                    slot_out_next   = 4'(slot_reg);
                    pos_out_next    = 32'd0;
                    data_out_next   = ring_rdata_reg;
                    wake_next       = (waiting_reg != 8'd0);
                    waiting_next    = 8'd0;
                    read_total_next = read_total_reg + 32'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_total_reg <= 32'd0;
            read_total_reg  <= 32'd0;
            prod_slot_reg   <= '0;
            cons_slot_reg   <= '0;
            taken_reg       <= '0;
            ready_reg       <= '0;
            pos_vld_reg     <= '0;
            waiting_reg     <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_total_reg <= write_total_next;
            read_total_reg  <= read_total_next;
            prod_slot_reg   <= prod_slot_next;
            cons_slot_reg   <= cons_slot_next;
            taken_reg       <= taken_next;
            ready_reg       <= ready_next;
            pos_vld_reg     <= pos_vld_next;
            waiting_reg     <= waiting_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // captured request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            amount_reg <= amount;
            slot_reg   <= in_slot;
            wpos_reg   <= write_position;
            din_reg    <= data_in;
        end
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        pos_out_reg  <= pos_out_next;
        data_out_reg <= data_out_next;
        wake_reg     <= wake_next;
    end

    // slot position memory, read issued with the request
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (accept)
        begin
            pos_rdata_reg <= pos_mem[pos_raddr];
            pos_rvld_reg  <= pos_vld_reg[pos_raddr];
        end
    end

    // byte ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wpos_reg[AW-1:0]] <= din_reg;
        end
        if (ring_re)
        begin
            ring_rdata_reg <= ring_mem[ring_raddr];
        end
    end

    // checks
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOOK))
        else $error("accepted request did not move to slot lookup");

    a_fetch_only_consume: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (cmd_reg == CMD_CONSUME_BYTE))
        else $error("ring fetch for a command other than consume byte");

    a_grant_marks_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && fire && cmd_reg == CMD_PRODUCE_ACQUIRE
         && !taken_reg[prod_slot_reg]) |=> taken_reg[$past(prod_slot_reg)])
        else $error("granted producer slot not marked taken");

    a_read_clears_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH && fire) |=> (waiting_reg == 8'd0 && out_valid_reg))
        else $error("consume byte did not clear waiting writers");

endmodule

`default_nettype wire
